// ----- hw/rtl/vswrpm_pkg.sv -----
// Shared types, widths, calibration constants and helpers for the VSWR power meter.
// No dependencies; every other file of the block imports this package.
package vswrpm_pkg;

    // Field widths fixed by the item format.
    localparam int ADC_FIELD_W = 16;
    localparam int POWER_W     = 19;
    localparam int VSWR_W      = 18;
    localparam int FLOOR_W     = 15;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_FLOOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VSWR_CAP  = 1'b1;
    localparam logic [FLOOR_W-1:0]   FLOOR_RESET   = 15'd500;
    localparam logic [VSWR_W-1:0]    CAP_RESET     = 18'd255974;

    // Horner datapath: accumulator in Q.16 watts, sample in Q0.15.
    localparam int ACC_W    = 34;
    localparam int PROD_W   = ACC_W + ADC_FIELD_W;
    localparam int HORNER_N = 5;

    // VSWR datapath.
    localparam int SQ_IN_W   = 56;
    localparam int SQ_OUT_W  = 28;
    localparam int SQ_SHIFT  = 18;
    localparam int NUM_W     = POWER_W + 10;
    localparam int DEN_W     = POWER_W + 8;
    localparam int QUO_W     = 19;

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic [POWER_W-1:0]      t_power;

    // Side information carried alongside the square root.
    typedef struct packed {
        t_power fwd;
        t_power rev;
        logic   f_zero;
        logic   r_ge;
    } t_vs_side;

    // Side information carried alongside the divider.
    typedef struct packed {
        t_vs_side vs;
        logic     ovf;
    } t_div_side;

    localparam t_power POWER_MAX = '1;

    // Calibration polynomial, highest power first, Q.16 watts.
    localparam t_acc HORNER_COEF [HORNER_N+1] = '{
        -34'sd687385986, 34'sd946651210, -34'sd465796292,
        34'sd121728285, -34'sd3267588, 34'sd19906
    };

    // Drop 15 fraction bits, rounding to nearest with ties away from zero.
    function automatic t_acc rnd_q15(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] m;
        logic [PROD_W-1:0] r;
        t_acc              t;
        m = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        r = (m + (PROD_W'(1) << 14)) >> 15;
        t = ACC_W'(r);
        return p[PROD_W-1] ? -t : t;
    endfunction

endpackage

// ----- hw/rtl/vswrpm_if.sv -----
// Valid/ready channel interfaces for sample items, result items and register writes.
// Depends on vswrpm_pkg.
interface vswrpm_in_if;
    import vswrpm_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [ADC_FIELD_W-1:0] forward_adc;
    logic signed [ADC_FIELD_W-1:0] reverse_adc;
    modport source (output valid, forward_adc, reverse_adc, input ready);
    modport sink   (input valid, forward_adc, reverse_adc, output ready);
endinterface

interface vswrpm_out_if;
    import vswrpm_pkg::*;
    logic               valid;
    logic               ready;
    logic [POWER_W-1:0] forward_power;
    logic [POWER_W-1:0] reverse_power;
    logic [VSWR_W-1:0]  vswr;
    logic               vswr_capped;
    modport source (output valid, forward_power, reverse_power, vswr, vswr_capped,
                    input ready);
    modport sink   (input valid, forward_power, reverse_power, vswr, vswr_capped,
                    output ready);
endinterface

interface vswrpm_cfg_if;
    import vswrpm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/vswr_power_meter.sv -----
// Top level of the VSWR power meter: registers, pipeline glue and output register.
// Depends on vswrpm_pkg, vswrpm_if, vswrpm_power, vswrpm_sqrt and vswrpm_div.
//
// Each item is a forward/reverse ADC sample pair; each produces exactly one result
// item with both powers in 2^-FRAC_BITS W and the VSWR in 2^-FRAC_BITS units.
// The block is a fixed 57-stage pipeline: 7 stages of calibration (sample register,
// five Horner steps of one multiply each, then magnitude and saturation), 1 stage
// for the power product, 28 square-root stages (one root bit each), 1 stage to form
// numerator and denominator, 19 divider stages (one quotient bit each) and the
// output register. It takes one item per clock whenever the pipeline advances. The
// edge that accepts an item loads the first stage. The whole pipeline advances
// whenever the output register is empty or being taken; while a result waits
// unread, input ready is low. Register writes are taken at any time on their own
// channel, but must only be issued with no item in flight.
module vswr_power_meter #(
    parameter int ADC_WIDTH = 16,
    parameter int FRAC_BITS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vswrpm_in_if.sink    i_in,
    vswrpm_out_if.source o_out,
    vswrpm_cfg_if.sink   i_cfg
);
    import vswrpm_pkg::*;

    localparam int XW = NUM_W + FRAC_BITS + 1;
    localparam int CW = (XW > DEN_W + QUO_W) ? XW : DEN_W + QUO_W;

    logic [FLOOR_W-1:0] r_adc_floor;
    logic [VSWR_W-1:0]  r_vswr_cap;
    logic               w_en;

    // Configuration registers.
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_floor <= FLOOR_RESET;
            r_vswr_cap  <= CAP_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_ADC_FLOOR: r_adc_floor <= i_cfg.data[FLOOR_W-1:0];
                CFG_VSWR_CAP:  r_vswr_cap  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Calibration lanes.
    logic   w_pw_valid;
    t_power w_fwd;
    t_power w_rev;

    vswrpm_power #(
        .ADC_WIDTH (ADC_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_power (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (i_in.valid),
        .i_fwd_adc   (i_in.forward_adc),
        .i_rev_adc   (i_in.reverse_adc),
        .i_adc_floor (r_adc_floor),
        .o_valid     (w_pw_valid),
        .o_fwd_power (w_fwd),
        .o_rev_power (w_rev)
    );

    // Product stage: 4 * F * R * 2^16 for the square root.
    logic               r_p_valid;
    logic [SQ_IN_W-1:0] r_p_rad;
    t_vs_side           r_p_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_rad         <= SQ_IN_W'((2*POWER_W)'(w_fwd) * (2*POWER_W)'(w_rev)) << SQ_SHIFT;
            r_p_side.fwd    <= w_fwd;
            r_p_side.rev    <= w_rev;
            r_p_side.f_zero <= (w_fwd == '0);
            r_p_side.r_ge   <= (w_rev >= w_fwd);
        end
    end

    // Square root of the scaled product.
    logic                w_sq_valid;
    logic [SQ_OUT_W-1:0] w_root;
    t_vs_side            w_sq_side;

    vswrpm_sqrt #(
        .SIDE_W ($bits(t_vs_side))
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_p_valid),
        .i_radicand (r_p_rad),
        .i_side     (r_p_side),
        .o_valid    (w_sq_valid),
        .o_root     (w_root),
        .o_side     (w_sq_side)
    );

    // Numerator and denominator of the ratio, and the quotient overflow test.
    logic [NUM_W-1:0] w_num;
    logic [DEN_W-1:0] w_den;
    logic [XW-1:0]    w_x;
    logic             r_d_valid;
    logic [XW-1:0]    r_d_x;
    logic [DEN_W-1:0] r_d_den;
    t_div_side        r_d_side;

    always_comb begin
        w_num = (NUM_W'(w_sq_side.fwd) + NUM_W'(w_sq_side.rev)) * NUM_W'(256)
                + NUM_W'(w_root);
        w_den = (DEN_W'(w_sq_side.fwd) - DEN_W'(w_sq_side.rev)) << 8;
        w_x   = (XW'(w_num) << FRAC_BITS) + XW'(w_den >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_x        <= w_x;
            r_d_den      <= w_den;
            r_d_side.vs  <= w_sq_side;
            r_d_side.ovf <= (CW'(w_x) >= (CW'(w_den) << QUO_W));
        end
    end

    // Division.
    logic             w_dv_valid;
    logic [QUO_W-1:0] w_quot;
    t_div_side        w_dv_side;

    vswrpm_div #(
        .XW     (XW),
        .DW     (DEN_W),
        .SIDE_W ($bits(t_div_side))
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_d_valid),
        .i_dividend (r_d_x),
        .i_divisor  (r_d_den),
        .i_side     (r_d_side),
        .o_valid    (w_dv_valid),
        .o_quot     (w_quot),
        .o_side     (w_dv_side)
    );

    // Output register: special cases and the cap.
    logic              r_out_valid;
    t_power            r_out_fwd;
    t_power            r_out_rev;
    logic [VSWR_W-1:0] r_out_vswr;
    logic              r_out_capped;

    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_dv_side.vs.f_zero) begin
                r_out_fwd    <= '0;
                r_out_rev    <= '0;
                r_out_vswr   <= '0;
                r_out_capped <= 1'b0;
            end else begin
                r_out_fwd <= w_dv_side.vs.fwd;
                r_out_rev <= w_dv_side.vs.rev;
                if (w_dv_side.vs.r_ge || w_dv_side.ovf
                    || w_quot > QUO_W'(r_vswr_cap)) begin
                    r_out_vswr   <= r_vswr_cap;
                    r_out_capped <= 1'b1;
                end else begin
                    r_out_vswr   <= VSWR_W'(w_quot);
                    r_out_capped <= 1'b0;
                end
            end
        end
    end

    // Valid bits of the glue stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_p_valid   <= w_pw_valid;
            r_d_valid   <= w_sq_valid;
            r_out_valid <= w_dv_valid;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.forward_power = r_out_fwd;
    assign o_out.reverse_power = r_out_rev;
    assign o_out.vswr          = r_out_vswr;
    assign o_out.vswr_capped   = r_out_capped;

    // A capped result always has forward power.
    a_capped_has_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.vswr_capped) |-> (o_out.forward_power != '0))
        else $error("capped VSWR with zero forward power");

    // No forward power zeroes the whole result.
    a_zero_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.forward_power == '0)
        |-> (o_out.reverse_power == '0 && o_out.vswr == '0 && !o_out.vswr_capped))
        else $error("nonzero fields with zero forward power");

    // An uncapped ratio implies reverse below forward.
    a_uncapped_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.vswr_capped && o_out.forward_power != '0)
        |-> (o_out.reverse_power < o_out.forward_power))
        else $error("uncapped VSWR with reverse at or above forward");

    // Nothing comes out right after reset.
    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result valid right after reset");

endmodule

// ----- hw/rtl/vswrpm_power.sv -----
// Two-lane pipelined calibration: ADC sample to power through a degree-5 Horner chain.
// Depends on vswrpm_pkg.
module vswrpm_power #(
    parameter int ADC_WIDTH = 16,
    parameter int FRAC_BITS = 8
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_en,
    input  logic                                        i_valid,
    input  logic signed [vswrpm_pkg::ADC_FIELD_W-1:0]   i_fwd_adc,
    input  logic signed [vswrpm_pkg::ADC_FIELD_W-1:0]   i_rev_adc,
    input  logic [vswrpm_pkg::FLOOR_W-1:0]              i_adc_floor,
    output logic                                        o_valid,
    output vswrpm_pkg::t_power                          o_fwd_power,
    output vswrpm_pkg::t_power                          o_rev_power
);
    import vswrpm_pkg::*;

    localparam int LANES  = 2;
    localparam int STAGES = HORNER_N + 2;
    localparam int SH     = ADC_FIELD_W - FRAC_BITS;
    localparam logic [ACC_W:0] HALF = ((ACC_W+1)'(1) << SH) >> 1;

    logic signed [ADC_FIELD_W-1:0] r_s    [LANES][HORNER_N];
    logic signed [ADC_FIELD_W-1:0] n_s    [LANES];
    logic                          r_zero [LANES][HORNER_N+1];
    logic                          n_zero [LANES];
    t_acc                          r_acc  [LANES][HORNER_N];
    t_acc                          n_acc  [LANES][HORNER_N];
    t_power                        r_pow  [LANES];
    t_power                        n_pow  [LANES];
    logic                          r_valid [STAGES];

    // Sample scaling and floor test.
    always_comb begin
        logic signed [ADC_WIDTH-1:0] raw;
        for (int l = 0; l < LANES; l++) begin
            raw = (l == 0) ? i_fwd_adc[ADC_WIDTH-1:0] : i_rev_adc[ADC_WIDTH-1:0];
            n_s[l] = ADC_FIELD_W'(raw) << (ADC_FIELD_W - ADC_WIDTH);
            n_zero[l] = n_s[l] < $signed({1'b0, i_adc_floor});
        end
    end

    // One Horner step per stage: multiply, round, add the next coefficient.
    always_comb begin
        t_acc                     prev;
        logic signed [PROD_W-1:0] prod;
        for (int l = 0; l < LANES; l++) begin
            for (int k = 0; k < HORNER_N; k++) begin
                prev = (k == 0) ? HORNER_COEF[0] : r_acc[l][k-1];
                prod = PROD_W'(prev) * PROD_W'(r_s[l][k]);
                n_acc[l][k] = rnd_q15(prod) + HORNER_COEF[k+1];
            end
        end
    end

    // Magnitude, rescale to output units and saturate.
    always_comb begin
        logic [ACC_W-1:0] mag;
        logic [ACC_W:0]   scaled;
        for (int l = 0; l < LANES; l++) begin
            mag    = r_acc[l][HORNER_N-1][ACC_W-1]
                     ? ACC_W'(-r_acc[l][HORNER_N-1]) : ACC_W'(r_acc[l][HORNER_N-1]);
            scaled = ((ACC_W+1)'(mag) + HALF) >> SH;
            if (r_zero[l][HORNER_N]) begin
                n_pow[l] = '0;
            end else if (scaled > (ACC_W+1)'(POWER_MAX)) begin
                n_pow[l] = POWER_MAX;
            end else begin
                n_pow[l] = POWER_W'(scaled);
            end
        end
    end

    // Data registers advance with the pipeline.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                r_s[l][0]    <= n_s[l];
                r_zero[l][0] <= n_zero[l];
                for (int k = 0; k < HORNER_N; k++) begin
                    r_acc[l][k]    <= n_acc[l][k];
                    r_zero[l][k+1] <= r_zero[l][k];
                    if (k + 1 < HORNER_N) begin
                        r_s[l][k+1] <= r_s[l][k];
                    end
                end
                r_pow[l] <= n_pow[l];
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < STAGES; j++) begin
                r_valid[j] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int j = 1; j < STAGES; j++) begin
                r_valid[j] <= r_valid[j-1];
            end
        end
    end

    assign o_valid     = r_valid[STAGES-1];
    assign o_fwd_power = r_pow[0];
    assign o_rev_power = r_pow[1];

endmodule

// ----- hw/rtl/vswrpm_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, with a side channel.
// Depends on vswrpm_pkg.
module vswrpm_sqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [vswrpm_pkg::SQ_IN_W-1:0]    i_radicand,
    input  logic [SIDE_W-1:0]                 i_side,
    output logic                              o_valid,
    output logic [vswrpm_pkg::SQ_OUT_W-1:0]   o_root,
    output logic [SIDE_W-1:0]                 o_side
);
    import vswrpm_pkg::*;

    localparam int N     = SQ_OUT_W;
    localparam int RES_W = SQ_IN_W + 1;

    logic [SQ_IN_W-1:0] r_rem  [N];
    logic [SQ_IN_W-1:0] n_rem  [N];
    logic [RES_W-1:0]   r_res  [N];
    logic [RES_W-1:0]   n_res  [N];
    logic [SIDE_W-1:0]  r_side [N];
    logic               r_valid [N];

    // Each stage tries one power of four, largest first.
    always_comb begin
        logic [SQ_IN_W-1:0] rem_in;
        logic [RES_W-1:0]   res_in;
        logic [RES_W-1:0]   bit_w;
        logic [RES_W-1:0]   trial;
        for (int j = 0; j < N; j++) begin
            rem_in = (j == 0) ? i_radicand : r_rem[j-1];
            res_in = (j == 0) ? '0 : r_res[j-1];
            bit_w  = RES_W'(1) << (SQ_IN_W - 2 - 2 * j);
            trial  = res_in + bit_w;
            if (RES_W'(rem_in) >= trial) begin
                n_rem[j] = rem_in - SQ_IN_W'(trial);
                n_res[j] = (res_in >> 1) + bit_w;
            end else begin
                n_rem[j] = rem_in;
                n_res[j] = res_in >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < N; j++) begin
                r_rem[j]  <= n_rem[j];
                r_res[j]  <= n_res[j];
                r_side[j] <= (j == 0) ? i_side : r_side[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < N; j++) begin
                r_valid[j] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int j = 1; j < N; j++) begin
                r_valid[j] <= r_valid[j-1];
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_root  = SQ_OUT_W'(r_res[N-1]);
    assign o_side  = r_side[N-1];

endmodule

// ----- hw/rtl/vswrpm_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with a side channel.
// Depends on vswrpm_pkg. The dividend must be below divisor times two to the quotient width.
module vswrpm_div #(
    parameter int XW     = 38,
    parameter int DW     = 27,
    parameter int SIDE_W = 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [XW-1:0]                   i_dividend,
    input  logic [DW-1:0]                   i_divisor,
    input  logic [SIDE_W-1:0]               i_side,
    output logic                            o_valid,
    output logic [vswrpm_pkg::QUO_W-1:0]    o_quot,
    output logic [SIDE_W-1:0]               o_side
);
    import vswrpm_pkg::*;

    localparam int N  = QUO_W;
    localparam int CW = (XW > DW + QUO_W) ? XW : DW + QUO_W;

    logic [XW-1:0]     r_rem  [N];
    logic [XW-1:0]     n_rem  [N];
    logic [DW-1:0]     r_den  [N];
    logic [QUO_W-1:0]  r_q    [N];
    logic [QUO_W-1:0]  n_q    [N];
    logic [SIDE_W-1:0] r_side [N];
    logic              r_valid [N];

    // Stage j settles quotient bit N-1-j.
    always_comb begin
        logic [XW-1:0]    rem_in;
        logic [DW-1:0]    den_in;
        logic [QUO_W-1:0] q_in;
        logic [CW-1:0]    sub;
        for (int j = 0; j < N; j++) begin
            rem_in = (j == 0) ? i_dividend : r_rem[j-1];
            den_in = (j == 0) ? i_divisor : r_den[j-1];
            q_in   = (j == 0) ? '0 : r_q[j-1];
            sub    = CW'(den_in) << (N - 1 - j);
            n_q[j] = q_in;
            if (CW'(rem_in) >= sub) begin
                n_rem[j] = rem_in - XW'(sub);
                n_q[j][N-1-j] = 1'b1;
            end else begin
                n_rem[j] = rem_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < N; j++) begin
                r_rem[j]  <= n_rem[j];
                r_q[j]    <= n_q[j];
                r_den[j]  <= (j == 0) ? i_divisor : r_den[j-1];
                r_side[j] <= (j == 0) ? i_side : r_side[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < N; j++) begin
                r_valid[j] <= 1'b0;
            end
        end else if (i_en) begin
            r_valid[0] <= i_valid;
            for (int j = 1; j < N; j++) begin
                r_valid[j] <= r_valid[j-1];
            end
        end
    end

    assign o_valid = r_valid[N-1];
    assign o_quot  = r_q[N-1];
    assign o_side  = r_side[N-1];

endmodule

// ----- sim/vswr_power_meter_tb.sv -----
// Self-checking testbench for the VSWR power meter: sample pairs in, powers and VSWR out.
// Depends on vswrpm_pkg, vswrpm_if and the vswr_power_meter RTL.
module vswr_power_meter_tb;
    import vswrpm_pkg::*;

    typedef struct packed {
        logic signed [15:0] fwd;
        logic signed [15:0] rev;
    } t_sample;

    typedef struct packed {
        logic [18:0] fwd_pwr;
        logic [18:0] rev_pwr;
        logic [17:0] vswr;
        logic        capped;
    } t_reading;

    localparam int  PIPE_LAT   = 57;
    localparam longint CYC_MAX = 2000000;

    logic i_clk;
    logic i_rst_n;

    vswrpm_in_if  in_ch ();
    vswrpm_out_if out_ch ();
    vswrpm_cfg_if cfg_ch ();

    vswr_power_meter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // Calibration polynomial in Q.16 watts, highest power first.
    localparam longint POLY [6] = '{
        -64'sd687385986, 64'sd946651210, -64'sd465796292,
        64'sd121728285, -64'sd3267588, 64'sd19906
    };

    // Predictor copy of the registers.
    logic [14:0] floor_q;
    logic [17:0] cap_q;

    t_sample  pending_q[$];
    t_reading readings_q[$];

    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_cnt;
    int     n_errors;
    int     n_checked;
    int     n_capped;
    int     n_zero;
    longint cycles;

    // Clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Round the magnitude to nearest with ties away from zero, keeping sign.
    function automatic longint rnd_shift(input longint p, input int sh);
        longint m;
        m = (p < 0) ? -p : p;
        m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
        return (p < 0) ? -m : m;
    endfunction

    // Power in 1/256 W for one ADC sample.
    function automatic logic [18:0] sample_power(input logic signed [15:0] smp);
        longint s;
        longint acc;
        longint mag;
        s = longint'(smp);
        if (s < longint'(floor_q)) return '0;
        acc = POLY[0];
        for (int k = 1; k < 6; k++) acc = rnd_shift(acc * s, 15) + POLY[k];
        mag = (acc < 0) ? -acc : acc;
        mag = (mag + 128) >>> 8;
        return (mag > 524287) ? 19'h7FFFF : mag[18:0];
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v   -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    // Expected reading for one sample pair.
    function automatic t_reading meter_reading(input t_sample smp);
        t_reading        rd;
        longint unsigned f;
        longint unsigned r;
        longint unsigned d;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        f  = 64'(sample_power(smp.fwd));
        r  = 64'(sample_power(smp.rev));
        rd = '0;
        if (f == 0) begin
            return rd;
        end
        rd.fwd_pwr = f[18:0];
        rd.rev_pwr = r[18:0];
        if (r >= f) begin
            rd.vswr   = cap_q;
            rd.capped = 1'b1;
        end else begin
            d   = int_sqrt((f * r * 4) << 16);
            num = ((f + r) << 8) + d;
            den = (f - r) << 8;
            q   = ((num << 8) + (den >> 1)) / den;
            if (q > cap_q) begin
                rd.vswr   = cap_q;
                rd.capped = 1'b1;
            end else begin
                rd.vswr = q[17:0];
            end
        end
        return rd;
    endfunction

    // Driver: offers queued sample pairs, with random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_ch.ready) begin
            // Hold the item until it is taken.
        end else if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            in_ch.valid       <= 1'b1;
            in_ch.forward_adc <= pending_q[0].fwd;
            in_ch.reverse_adc <= pending_q[0].rev;
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // Acceptance at the rising edge: pop the queue and record the expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            readings_q.push_back(meter_reading({in_ch.forward_adc, in_ch.reverse_adc}));
            void'(pending_q.pop_front());
        end
    end

    // Receiver ready, with random stalls or a long hold-off counted down here.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            out_ch.ready <= 1'b0;
            hold_cnt     <= hold_cnt - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: compare each result with the oldest expectation.
    always @(posedge i_clk) begin
        t_reading ex;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (readings_q.size() == 0) begin
                $error("result with no expectation waiting");
                n_errors++;
            end else begin
                ex = readings_q.pop_front();
                n_checked++;
                if (ex.capped) n_capped++;
                if (ex.fwd_pwr == 0) n_zero++;
                if (out_ch.forward_power !== ex.fwd_pwr) begin
                    $error("forward_power: expected %0d, got %0d", ex.fwd_pwr,
                           out_ch.forward_power);
                    n_errors++;
                end
                if (out_ch.reverse_power !== ex.rev_pwr) begin
                    $error("reverse_power: expected %0d, got %0d", ex.rev_pwr,
                           out_ch.reverse_power);
                    n_errors++;
                end
                if (out_ch.vswr !== ex.vswr) begin
                    $error("vswr: expected %0d, got %0d", ex.vswr, out_ch.vswr);
                    n_errors++;
                end
                if (out_ch.vswr_capped !== ex.capped) begin
                    $error("vswr_capped: expected %0d, got %0d", ex.capped,
                           out_ch.vswr_capped);
                    n_errors++;
                end
            end
        end
    end

    // Cycle limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_MAX) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic wait_cycles(input int n);
        repeat (n) @(posedge i_clk);
    endtask

    // Let every queued item go in and every expected result come out.
    task automatic drain();
        while (pending_q.size() > 0 || in_ch.valid || readings_q.size() > 0)
            @(posedge i_clk);
        wait_cycles(PIPE_LAT + 5);
    endtask

    // One register write on the configuration channel, block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [17:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx == CFG_ADC_FLOOR) floor_q = val[14:0];
        else                      cap_q   = val;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_adc();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(65535));
            1:       return 16'($urandom_range(3000));
            2:       return 16'($urandom_range(32767, 20000));
            default: return 16'($urandom_range(20000));
        endcase
    endfunction

    task automatic queue_random(input int n);
        t_sample smp;
        for (int i = 0; i < n; i++) begin
            smp.fwd = rand_adc();
            // Mostly reverse below forward so that real VSWR values appear.
            smp.rev = ($urandom_range(3) == 0)
                      ? rand_adc()
                      : 16'($urandom_range(smp.fwd < 0 ? 0 : smp.fwd));
            pending_q.push_back(smp);
        end
    endtask

    localparam logic signed [15:0] DIRECTED [20][2] = '{
        '{16'sh7FFF, 16'sh0000}, '{16'sh8000, 16'sh7FFF}, '{16'sh7FFF, 16'sh7FFF},
        '{16'sh7FFF, 16'sh8000}, '{16'sh8000, 16'sh8000}, '{16'sh01F4, 16'sh01F3},
        '{16'sh01F3, 16'sh01F4}, '{16'sh0000, 16'sh0000}, '{16'sh4000, 16'sh2000},
        '{16'sh4000, 16'sh4000}, '{16'sh2000, 16'sh4000}, '{16'sh7FFF, 16'sh7F00},
        '{16'sh7FFF, 16'sh0200}, '{16'sh1000, 16'sh0800}, '{16'shFFFF, 16'sh5555},
        '{16'sh5555, 16'shAAAA}, '{16'sh2AAA, 16'sh1555}, '{16'sh6000, 16'sh5FF0},
        '{16'sh0FFF, 16'sh0FFE}, '{16'sh7000, 16'sh01F4}
    };

    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.forward_adc = '0;
        in_ch.reverse_adc = '0;
        out_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_ADC_FLOOR;
        cfg_ch.data      = '0;
        floor_q          = FLOOR_RESET;
        cap_q            = CAP_RESET;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        hold_cnt         = 0;
        n_errors         = 0;
        n_checked        = 0;
        n_capped         = 0;
        n_zero           = 0;
        cycles           = 0;
        wait_cycles(10);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed corners under reset register values.
        for (int i = 0; i < 20; i++) pending_q.push_back({DIRECTED[i][0], DIRECTED[i][1]});
        drain();

        // Zero floor and smallest cap, then full floor and a low cap.
        write_reg(CFG_ADC_FLOOR, 18'd0);
        write_reg(CFG_VSWR_CAP, 18'd256);
        send_idle_pct = 17;
        recv_idle_pct = 80;
        queue_random(500);
        drain();

        write_reg(CFG_ADC_FLOOR, 18'd32767);
        write_reg(CFG_VSWR_CAP, 18'd1000);
        for (int i = 0; i < 4; i++) pending_q.push_back({16'sh7FFF, 16'sh7FFE});
        queue_random(20);
        drain();

        // Middle settings; receiver holds off long so the pipeline backs up.
        write_reg(CFG_ADC_FLOOR, 18'd100);
        write_reg(CFG_VSWR_CAP, 18'd255974);
        send_idle_pct = 80;
        recv_idle_pct = 17;
        queue_random(500);
        send_idle_pct = 0;
        hold_cnt      = 300;
        wait (hold_cnt == 0);
        send_idle_pct = 80;
        drain();

        // Reset-level floor, no idling at all.
        write_reg(CFG_ADC_FLOOR, 18'd500);
        write_reg(CFG_VSWR_CAP, 18'd2560);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(1000);
        drain();

        $display("checked %0d readings, %0d capped VSWR, %0d with no forward power",
                 n_checked, n_capped, n_zero);
        $display("register settings covered floor 0..32767 and cap 256..255974");
        if (n_errors == 0 && readings_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
